@@ rtl/cvme_pkg.sv @@
// Controller value message encoder package: codes, controller numbers and
// the descriptor passed from the front end through the queue to the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cvme_pkg;

  // Input controller kinds
  localparam logic [2:0] KIND_TEMPO    = 3'd0;
  localparam logic [2:0] KIND_CC7      = 3'd1;
  localparam logic [2:0] KIND_CC14     = 3'd2;
  localparam logic [2:0] KIND_NRPN     = 3'd3;
  localparam logic [2:0] KIND_RPN      = 3'd4;
  localparam logic [2:0] KIND_PRESSURE = 3'd5;
  localparam logic [2:0] KIND_BEND     = 3'd6;

  // Output message kinds
  localparam logic [1:0] MSG_TEMPO    = 2'd0;
  localparam logic [1:0] MSG_CC       = 2'd1;
  localparam logic [1:0] MSG_PRESSURE = 2'd2;
  localparam logic [1:0] MSG_BEND     = 2'd3;

  // Controller numbers
  localparam logic [6:0] CC_LSB_OFFSET = 7'h20;
  localparam logic [6:0] CC_NRPN_LSB   = 7'h62;
  localparam logic [6:0] CC_NRPN_MSB   = 7'h63;
  localparam logic [6:0] CC_RPN_LSB    = 7'h64;
  localparam logic [6:0] CC_RPN_MSB    = 7'h65;
  localparam logic [6:0] CC_DATA_MSB   = 7'h06;
  localparam logic [6:0] CC_DATA_LSB   = 7'h26;

  // Configuration register indexes
  localparam logic CFG_TEMPO_LOW  = 1'b0;
  localparam logic CFG_TEMPO_HIGH = 1'b1;

  localparam logic [23:0] TEMPO_LOW_RESET  = 24'd1;
  localparam logic [23:0] TEMPO_HIGH_RESET = 24'hffffff;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    OP_ERROR,
    OP_TEMPO,
    OP_CC7,
    OP_CC14,
    OP_NRPN,
    OP_RPN,
    OP_PRESSURE,
    OP_BEND
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [4:0]         channel;
    logic [13:0]        index;
    logic [23:0]        value;
    logic signed [31:0] moment;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

@@ rtl/controller_value_message_encoder_top.sv @@
// Controller value message encoder top level: front end, descriptor queue and
// back end. Depends on cvme_pkg, cvme_front, cvme_queue, cvme_back.
//
// Usage:
//   Input channel: an update (ctl_kind, channel, ctl_index, new_value, moment)
//   transfers when push is high and full is low. Result channel: the oldest
//   message sits on the result ports while empty is low and transfers when
//   pop is high. Configuration: cfg_index 0 writes tempo_low, 1 tempo_high;
//   cfg_ready is always high.
//   Each update yields 1, 2 or 4 results (4 for parameter kinds), the last
//   marked by last_of_run; a value out of range yields one range_error result.
//   The first result of an update passes through the descriptor queue and
//   then the output register. The back end emits one result per cycle while
//   the receiver pops, so the update rate depends on each update's result count.
//   A 4-entry descriptor queue separates input from output: updates keep
//   transferring while the receiver stalls until the queue fills, then full
//   rises; no result is lost or dropped.
//   Reset empties the queue and output register and restores tempo limits
//   to 1 and 16777215.
`timescale 1ns / 1ps
`default_nettype none

module controller_value_message_encoder_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         ctl_kind,
  input  wire logic [4:0]         channel,
  input  wire logic [13:0]        ctl_index,
  input  wire logic signed [31:0] new_value,
  input  wire logic signed [31:0] moment,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              msg_kind,
  output logic                    range_error,
  output logic signed [31:0]      out_moment,
  output logic [4:0]              out_channel,
  output logic [6:0]              data_one,
  output logic [23:0]             data_two,
  output logic                    last_of_run,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [23:0]        cfg_data
);
  import cvme_pkg::*;

  queue_status_t q_status;
  logic          q_write;
  logic          q_read;
  desc_t         q_wdata;
  desc_t         q_rdata;

  assign full = q_status.full;

  cvme_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .ctl_kind  (ctl_kind),
    .channel   (channel),
    .ctl_index (ctl_index),
    .new_value (new_value),
    .moment    (moment),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .q_write   (q_write),
    .q_wdata   (q_wdata)
  );

  cvme_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .write  (q_write),
    .wdata  (q_wdata),
    .read   (q_read),
    .rdata  (q_rdata),
    .status (q_status)
  );

  cvme_back u_back (
    .clk         (clk),
    .rst         (rst),
    .desc        (q_rdata),
    .q_status    (q_status),
    .q_read      (q_read),
    .empty       (empty),
    .pop         (pop),
    .msg_kind    (msg_kind),
    .range_error (range_error),
    .out_moment  (out_moment),
    .out_channel (out_channel),
    .data_one    (data_one),
    .data_two    (data_two),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

@@ rtl/cvme_front.sv @@
// Front end: holds the tempo limit registers, range-checks each update and
// turns it into a descriptor for the queue. Depends on cvme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cvme_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic [2:0]         ctl_kind,
  input  wire logic [4:0]         channel,
  input  wire logic [13:0]        ctl_index,
  input  wire logic signed [31:0] new_value,
  input  wire logic signed [31:0] moment,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [23:0]        cfg_data,
  input  wire cvme_pkg::queue_status_t q_status,
  output logic                    q_write,
  output cvme_pkg::desc_t         q_wdata
);
  import cvme_pkg::*;

  logic [23:0] tempo_low;
  logic [23:0] tempo_high;
  logic        neg;
  logic        fits7;
  logic        fits14;
  logic        fits24;
  logic        tempo_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tempo_low  <= TEMPO_LOW_RESET;
      tempo_high <= TEMPO_HIGH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TEMPO_LOW:  tempo_low  <= cfg_data;
        CFG_TEMPO_HIGH: tempo_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign neg      = new_value[31];
  assign fits7    = !neg && (new_value[30:7] == '0);
  assign fits14   = !neg && (new_value[30:14] == '0);
  assign fits24   = !neg && (new_value[30:24] == '0);
  assign tempo_ok = fits24 && (new_value[23:0] >= tempo_low)
                    && (new_value[23:0] <= tempo_high);

  assign q_write = push && !q_status.full;

  always_comb begin
    q_wdata.channel = channel;
    q_wdata.index   = ctl_index;
    q_wdata.value   = new_value[23:0];
    q_wdata.moment  = moment;
    q_wdata.op      = OP_ERROR;
    case (ctl_kind)
      KIND_TEMPO:    q_wdata.op = tempo_ok ? OP_TEMPO : OP_ERROR;
      KIND_CC7:      q_wdata.op = fits7 ? OP_CC7 : OP_ERROR;
      KIND_CC14:     q_wdata.op = fits14 ? OP_CC14 : OP_ERROR;
      KIND_NRPN:     q_wdata.op = fits14 ? OP_NRPN : OP_ERROR;
      KIND_RPN:      q_wdata.op = fits14 ? OP_RPN : OP_ERROR;
      KIND_PRESSURE: q_wdata.op = fits7 ? OP_PRESSURE : OP_ERROR;
      KIND_BEND:     q_wdata.op = fits14 ? OP_BEND : OP_ERROR;
      default:       q_wdata.op = OP_ERROR;
    endcase
    if (ctl_kind == KIND_TEMPO) begin
      q_wdata.channel = '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cvme_queue.sv @@
// Descriptor queue between front and back end, QUEUE_DEPTH entries.
// Depends on cvme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cvme_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            write,
  input  wire cvme_pkg::desc_t wdata,
  input  wire logic            read,
  output cvme_pkg::desc_t      rdata,
  output cvme_pkg::queue_status_t status
);
  import cvme_pkg::*;

  desc_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic                  do_write;
  logic                  do_read;

  assign status.full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_write     = write && !status.full;
  assign do_read      = read && !status.empty;
  assign rdata        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_write) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_read) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_write, do_read})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/cvme_back.sv @@
// Back end: steps through the head descriptor's messages into the output
// register, one per cycle while it is free or popped. Depends on cvme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cvme_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cvme_pkg::desc_t    desc,
  input  wire cvme_pkg::queue_status_t q_status,
  output logic                    q_read,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              msg_kind,
  output logic                    range_error,
  output logic signed [31:0]      out_moment,
  output logic [4:0]              out_channel,
  output logic [6:0]              data_one,
  output logic [23:0]             data_two,
  output logic                    last_of_run
);
  import cvme_pkg::*;

  logic [1:0]  step;
  logic [1:0]  last_step;
  logic        out_valid;
  logic        load;
  logic        is_last;
  logic [1:0]  kind_c;
  logic        err_c;
  logic [4:0]  ch_c;
  logic [6:0]  d1_c;
  logic [23:0] d2_c;
  logic [6:0]  ilo;
  logic [6:0]  ihi;
  logic [6:0]  vlo;
  logic [6:0]  vhi;

  assign ilo = desc.index[6:0];
  assign ihi = desc.index[13:7];
  assign vlo = desc.value[6:0];
  assign vhi = desc.value[13:7];

  always_comb begin
    case (desc.op)
      OP_CC14:         last_step = 2'd1;
      OP_NRPN, OP_RPN: last_step = 2'd3;
      default:         last_step = 2'd0;
    endcase
  end

  assign is_last = (step == last_step);
  assign load    = !q_status.empty && (!out_valid || pop);
  assign q_read  = load && is_last;
  assign empty   = !out_valid;

  always_comb begin
    kind_c = MSG_CC;
    err_c  = 1'b0;
    ch_c   = desc.channel;
    d1_c   = '0;
    d2_c   = '0;
    case (desc.op)
      OP_ERROR: begin
        kind_c = MSG_TEMPO;
        err_c  = 1'b1;
      end
      OP_TEMPO: begin
        kind_c = MSG_TEMPO;
        ch_c   = '0;
        d2_c   = desc.value;
      end
      OP_CC7: begin
        d1_c = ilo;
        d2_c = {17'd0, vlo};
      end
      OP_CC14: begin
        if (step == 2'd0) begin
          d1_c = ilo;
          d2_c = {17'd0, vhi};
        end else begin
          d1_c = 7'(ilo + CC_LSB_OFFSET);
          d2_c = {17'd0, vlo};
        end
      end
      OP_NRPN, OP_RPN: begin
        case (step)
          2'd0: begin
            d1_c = (desc.op == OP_NRPN) ? CC_NRPN_LSB : CC_RPN_LSB;
            d2_c = {17'd0, ilo};
          end
          2'd1: begin
            d1_c = (desc.op == OP_NRPN) ? CC_NRPN_MSB : CC_RPN_MSB;
            d2_c = {17'd0, ihi};
          end
          2'd2: begin
            d1_c = CC_DATA_MSB;
            d2_c = {17'd0, vhi};
          end
          default: begin
            d1_c = CC_DATA_LSB;
            d2_c = {17'd0, vlo};
          end
        endcase
      end
      OP_PRESSURE: begin
        kind_c = MSG_PRESSURE;
        d2_c   = {17'd0, vlo};
      end
      OP_BEND: begin
        kind_c = MSG_BEND;
        d2_c   = {10'd0, desc.value[13:0]};
      end
      default: begin
        kind_c = MSG_TEMPO;
        err_c  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= is_last ? 2'd0 : step + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      msg_kind    <= kind_c;
      range_error <= err_c;
      out_moment  <= desc.moment;
      out_channel <= ch_c;
      data_one    <= d1_c;
      data_two    <= d2_c;
      last_of_run <= is_last;
    end
  end

endmodule

`default_nettype wire
